[src/jsu_pkg.sv]
// jsu_pkg: shared types, error codes and character constants for the
// json string unescape block. Used by every module under src.
package jsu_pkg;

    // error codes carried in error_code
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NO_OPEN    = 3'd1;
    localparam logic [2:0] ERR_UNTERM     = 3'd2;
    localparam logic [2:0] ERR_END_ESC    = 3'd3;
    localparam logic [2:0] ERR_END_UNI    = 3'd4;
    localparam logic [2:0] ERR_BAD_HEX    = 3'd5;
    localparam logic [2:0] ERR_BAD_ESC    = 3'd6;

    // characters
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_BS_CTRL   = 8'h08;
    localparam logic [7:0] CH_FF_CTRL   = 8'h0C;
    localparam logic [7:0] CH_LF_CTRL   = 8'h0A;
    localparam logic [7:0] CH_CR_CTRL   = 8'h0D;
    localparam logic [7:0] CH_TAB_CTRL  = 8'h09;

    // utf-8 encoding constants
    localparam logic [15:0] UTF_MAX1  = 16'h007F;
    localparam logic [15:0] UTF_MAX2  = 16'h07FF;
    localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF_CONT  = 8'h80;
    localparam logic [7:0]  UTF_MASK6 = 8'h3F;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last;
        logic       string_done;
        logic [2:0] error_code;
    } out_t;

    // results produced by one input transaction
    typedef struct packed {
        logic [1:0]                   count;
        out_t [MAX_RESULTS-1:0]       res;
    } step_t;

    // returns {is_hex, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic out_t mk_res(input logic [7:0] b, input logic hb,
                                    input logic done, input logic [2:0] err);
        out_t r;
        r.out_byte    = b;
        r.has_byte    = hb;
        r.last        = 1'b0;
        r.string_done = done;
        r.error_code  = err;
        return r;
    endfunction

endpackage

[src/json_string_unescape.sv]
// json_string_unescape: top level, input register feeding the decoder and
// the result buffer. Depends on jsu_pkg, jsu_decode, jsu_result_buf.
//
//  channel | signals                     | payload
//  --------+-----------------------------+------------------------------
//  input   | in_valid, in_stall, in_data | in_byte, end_of_input
//  output  | out_valid, out_stall, out_data | out_byte, has_byte, last,
//          |                             | string_done, error_code
//
// one byte per cycle unless in_stall is high; a result passes through the input
// register and the result buffer; a \u escape that yields 2 or 3 utf-8 bytes
// holds the input while the result buffer drains, one result per cycle unless stalled
// reset puts the parser back to waiting for an opening quote
// out_stall propagates combinationally to in_stall through the buffer
module json_string_unescape (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  jsu_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output jsu_pkg::out_t out_data
);

    logic           item_valid_reg;
    jsu_pkg::in_t   item_reg;
    logic           can_load;
    logic           move;
    jsu_pkg::step_t step_data;

    assign move     = item_valid_reg && can_load;
    assign in_stall = item_valid_reg && !can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_data;
        end
    end

    jsu_decode u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (move),
        .item   (item_reg),
        .result (step_data)
    );

    jsu_result_buf u_result_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (move),
        .step_data (step_data),
        .can_load  (can_load),
        .valid     (out_valid),
        .stall     (out_stall),
        .data      (out_data)
    );

    // a multi-byte sequence continues on the next cycle
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last |=> out_valid)
        else $error("result burst broken before last");

    // byte results never carry done or error
    a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.has_byte |->
            !out_data.string_done && out_data.error_code == jsu_pkg::ERR_NONE)
        else $error("byte result carries status");

    // input only held back while the input register is occupied
    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> item_valid_reg && out_valid)
        else $error("input stalled without pending work");

endmodule

[src/jsu_decode.sv]
// jsu_decode: string parsing state machine and per-byte decode logic.
// Produces up to three results for each byte it is stepped with.
// Depends on jsu_pkg.
module jsu_decode (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  jsu_pkg::in_t  item,
    output jsu_pkg::step_t result
);

    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_STRING  = 2'd1,
        PH_ESCAPE  = 2'd2,
        PH_UNICODE = 2'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [15:0] hex_value_reg, hex_value_next;
    logic        hex_run_ended_reg, hex_run_ended_next;
    logic        hex_first_bad_reg, hex_first_bad_next;

    logic [4:0]  hd;
    logic [15:0] cp;
    logic        first_bad;
    jsu_pkg::step_t st;

    always_comb
    begin
        phase_next         = phase_reg;
        hex_count_next     = hex_count_reg;
        hex_value_next     = hex_value_reg;
        hex_run_ended_next = hex_run_ended_reg;
        hex_first_bad_next = hex_first_bad_reg;
        st                 = '0;
        hd                 = jsu_pkg::hex_digit(item.in_byte);
        cp                 = hex_value_reg;
        first_bad          = hex_first_bad_reg;

        if (item.end_of_input)
        begin
            st.count  = 2'd1;
            phase_next = PH_WAIT;
            unique case (phase_reg)
                PH_WAIT:    st.res[0] = jsu_pkg::mk_res('0, 1'b0, 1'b0, jsu_pkg::ERR_NO_OPEN);
                PH_STRING:  st.res[0] = jsu_pkg::mk_res('0, 1'b0, 1'b0, jsu_pkg::ERR_UNTERM);
                PH_ESCAPE:  st.res[0] = jsu_pkg::mk_res('0, 1'b0, 1'b0, jsu_pkg::ERR_END_ESC);
                PH_UNICODE: st.res[0] = jsu_pkg::mk_res('0, 1'b0, 1'b0, jsu_pkg::ERR_END_UNI);
                default:    st.res[0] = jsu_pkg::mk_res('0, 1'b0, 1'b0, jsu_pkg::ERR_END_UNI);
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_WAIT:
                begin
                    if (item.in_byte == jsu_pkg::CH_QUOTE)
                    begin
                        phase_next = PH_STRING;
                    end
                    else
                    begin
                        st.count  = 2'd1;
                        st.res[0] = jsu_pkg::mk_res('0, 1'b0, 1'b0, jsu_pkg::ERR_NO_OPEN);
                    end
                end
                PH_STRING:
                begin
                    if (item.in_byte == jsu_pkg::CH_QUOTE)
                    begin
                        phase_next = PH_WAIT;
                        st.count   = 2'd1;
                        st.res[0]  = jsu_pkg::mk_res('0, 1'b0, 1'b1, jsu_pkg::ERR_NONE);
                    end
                    else if (item.in_byte == jsu_pkg::CH_BACKSLASH)
                    begin
                        phase_next = PH_ESCAPE;
                    end
                    else
                    begin
                        st.count  = 2'd1;
                        st.res[0] = jsu_pkg::mk_res(item.in_byte, 1'b1, 1'b0,
                                                    jsu_pkg::ERR_NONE);
                    end
                end
                PH_ESCAPE:
                begin
                    st.count   = 2'd1;
                    phase_next = PH_STRING;
                    case (item.in_byte)
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH:
                            st.res[0] = jsu_pkg::mk_res(item.in_byte, 1'b1, 1'b0,
                                                        jsu_pkg::ERR_NONE);
                        jsu_pkg::CH_B:
                            st.res[0] = jsu_pkg::mk_res(jsu_pkg::CH_BS_CTRL, 1'b1, 1'b0,
                                                        jsu_pkg::ERR_NONE);
                        jsu_pkg::CH_F:
                            st.res[0] = jsu_pkg::mk_res(jsu_pkg::CH_FF_CTRL, 1'b1, 1'b0,
                                                        jsu_pkg::ERR_NONE);
                        jsu_pkg::CH_N:
                            st.res[0] = jsu_pkg::mk_res(jsu_pkg::CH_LF_CTRL, 1'b1, 1'b0,
                                                        jsu_pkg::ERR_NONE);
                        jsu_pkg::CH_R:
                            st.res[0] = jsu_pkg::mk_res(jsu_pkg::CH_CR_CTRL, 1'b1, 1'b0,
                                                        jsu_pkg::ERR_NONE);
                        jsu_pkg::CH_T:
                            st.res[0] = jsu_pkg::mk_res(jsu_pkg::CH_TAB_CTRL, 1'b1, 1'b0,
                                                        jsu_pkg::ERR_NONE);
                        jsu_pkg::CH_U:
                        begin
                            st.count           = 2'd0;
                            phase_next         = PH_UNICODE;
                            hex_count_next     = 2'd0;
                            hex_value_next     = 16'd0;
                            hex_run_ended_next = 1'b0;
                            hex_first_bad_next = 1'b0;
                        end
                        default:
                        begin
                            phase_next = PH_WAIT;
                            st.res[0]  = jsu_pkg::mk_res('0, 1'b0, 1'b0,
                                                         jsu_pkg::ERR_BAD_ESC);
                        end
                    endcase
                end
                PH_UNICODE:
                begin
                    // leading run of hex digits builds the code unit
                    if (!hex_run_ended_reg && hd[4])
                    begin
                        cp = {hex_value_reg[11:0], hd[3:0]};
                    end
                    else
                    begin
                        hex_run_ended_next = 1'b1;
                        if (hex_count_reg == 2'd0)
                        begin
                            first_bad = 1'b1;
                        end
                    end
                    hex_value_next     = cp;
                    hex_first_bad_next = first_bad;
                    if (hex_count_reg != 2'd3)
                    begin
                        hex_count_next = hex_count_reg + 2'd1;
                    end
                    else if (first_bad)
                    begin
                        phase_next = PH_WAIT;
                        st.count   = 2'd1;
                        st.res[0]  = jsu_pkg::mk_res('0, 1'b0, 1'b0, jsu_pkg::ERR_BAD_HEX);
                    end
                    else
                    begin
                        phase_next = PH_STRING;
                        if (cp <= jsu_pkg::UTF_MAX1)
                        begin
                            st.count  = 2'd1;
                            st.res[0] = jsu_pkg::mk_res(cp[7:0], 1'b1, 1'b0,
                                                        jsu_pkg::ERR_NONE);
                        end
                        else if (cp <= jsu_pkg::UTF_MAX2)
                        begin
                            st.count  = 2'd2;
                            st.res[0] = jsu_pkg::mk_res(jsu_pkg::UTF_LEAD2 | {3'd0, cp[10:6]},
                                                        1'b1, 1'b0, jsu_pkg::ERR_NONE);
                            st.res[1] = jsu_pkg::mk_res(jsu_pkg::UTF_CONT |
                                                        ({2'd0, cp[5:0]} & jsu_pkg::UTF_MASK6),
                                                        1'b1, 1'b0, jsu_pkg::ERR_NONE);
                        end
                        else
                        begin
                            st.count  = 2'd3;
                            st.res[0] = jsu_pkg::mk_res(jsu_pkg::UTF_LEAD3 | {4'd0, cp[15:12]},
                                                        1'b1, 1'b0, jsu_pkg::ERR_NONE);
                            st.res[1] = jsu_pkg::mk_res(jsu_pkg::UTF_CONT |
                                                        ({2'd0, cp[11:6]} & jsu_pkg::UTF_MASK6),
                                                        1'b1, 1'b0, jsu_pkg::ERR_NONE);
                            st.res[2] = jsu_pkg::mk_res(jsu_pkg::UTF_CONT |
                                                        ({2'd0, cp[5:0]} & jsu_pkg::UTF_MASK6),
                                                        1'b1, 1'b0, jsu_pkg::ERR_NONE);
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase
        end

        // any return to string or wait leaves the unicode state clear
        if (phase_next != PH_UNICODE)
        begin
            hex_count_next     = 2'd0;
            hex_value_next     = 16'd0;
            hex_run_ended_next = 1'b0;
            hex_first_bad_next = 1'b0;
        end

        for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++)
        begin
            st.res[i].last = (st.count == 2'(i + 1));
        end
    end

    assign result = st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_WAIT;
            hex_count_reg     <= 2'd0;
            hex_value_reg     <= 16'd0;
            hex_run_ended_reg <= 1'b0;
            hex_first_bad_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            hex_count_reg     <= hex_count_next;
            hex_value_reg     <= hex_value_next;
            hex_run_ended_reg <= hex_run_ended_next;
            hex_first_bad_reg <= hex_first_bad_next;
        end
    end

endmodule

[src/jsu_result_buf.sv]
// jsu_result_buf: holds the results of one decoded transaction and hands
// them out one per cycle unless stalled on the output channel. Depends on jsu_pkg.
module jsu_result_buf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  jsu_pkg::step_t step_data,
    output logic           can_load,
    output logic           valid,
    input  logic           stall,
    output jsu_pkg::out_t  data
);

    jsu_pkg::out_t [jsu_pkg::MAX_RESULTS-1:0] res_reg;
    logic [1:0] left_reg;
    logic [1:0] idx_reg;
    logic       pop;

    assign valid    = (left_reg != 2'd0);
    assign pop      = valid && !stall;
    // reload when empty or once the last held result leaves this cycle
    assign can_load = (left_reg == 2'd0) || (left_reg == 2'd1 && pop);
    assign data     = res_reg[idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= 2'd0;
            idx_reg  <= 2'd0;
        end
        else if (load)
        begin
            left_reg <= step_data.count;
            idx_reg  <= 2'd0;
        end
        else if (pop)
        begin
            left_reg <= left_reg - 2'd1;
            idx_reg  <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= step_data.res;
        end
    end

endmodule

[tb/jsu_tb_pkg.sv]
// jsu_tb_pkg: scoreboard for the json string unescape testbench, with its own
// decoder prediction and hex helpers. Depends on jsu_pkg for payload types.
package jsu_tb_pkg;

    import jsu_pkg::*;

    typedef enum logic [1:0] {SEEK_QUOTE, IN_TEXT, AFTER_ESCAPE, IN_UNICODE} parse_phase_t;

    // returns {is_hex, nibble}
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
        if (n < 4'd10)
        begin
            return 8'h30 + 8'(n);
        end
        return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    class decode_scoreboard;
        parse_phase_t phase;
        logic [1:0]   digits_seen;
        logic [15:0]  code_unit;
        logic         run_ended;
        logic         first_bad;
        out_t         decoded_q[$];
        int           mismatches;
        int           inputs_seen;
        int           checked;
        int           closed;
        int           bytes_out;
        int           error_hits[8];

        function new();
            phase = SEEK_QUOTE;
            clear_unicode();
            mismatches  = 0;
            inputs_seen = 0;
            checked     = 0;
            closed      = 0;
            bytes_out   = 0;
            foreach (error_hits[i])
            begin
                error_hits[i] = 0;
            end
        endfunction

        function void clear_unicode();
            digits_seen = 2'd0;
            code_unit   = 16'd0;
            run_ended   = 1'b0;
            first_bad   = 1'b0;
        endfunction

        function void append_result(out_t r);
            decoded_q = {decoded_q, r};
        endfunction

        function void push_result(logic [7:0] b, logic hb, logic done, logic [2:0] code);
            out_t r;
            r.out_byte    = b;
            r.has_byte    = hb;
            r.last        = 1'b0;
            r.string_done = done;
            r.error_code  = code;
            append_result(r);
        endfunction

        function void abort(logic [2:0] code);
            phase = SEEK_QUOTE;
            clear_unicode();
            push_result(8'h00, 1'b0, 1'b0, code);
        endfunction

        // predicts the results of one accepted input transaction
        function void note_input(in_t t);
            int         start;
            logic [4:0] nib;
            logic [15:0] cu;
            out_t       tail;
            start = decoded_q.size();
            inputs_seen++;
            if (t.end_of_input)
            begin
                case (phase)
                    SEEK_QUOTE:   abort(ERR_NO_OPEN);
                    IN_TEXT:      abort(ERR_UNTERM);
                    AFTER_ESCAPE: abort(ERR_END_ESC);
                    default:      abort(ERR_END_UNI);
                endcase
            end
            else
            begin
                case (phase)
                    SEEK_QUOTE:
                    begin
                        if (t.in_byte == CH_QUOTE)
                        begin
                            phase = IN_TEXT;
                        end
                        else
                        begin
                            abort(ERR_NO_OPEN);
                        end
                    end
                    IN_TEXT:
                    begin
                        if (t.in_byte == CH_QUOTE)
                        begin
                            phase = SEEK_QUOTE;
                            clear_unicode();
                            push_result(8'h00, 1'b0, 1'b1, ERR_NONE);
                        end
                        else if (t.in_byte == CH_BACKSLASH)
                        begin
                            phase = AFTER_ESCAPE;
                        end
                        else
                        begin
                            push_result(t.in_byte, 1'b1, 1'b0, ERR_NONE);
                        end
                    end
                    AFTER_ESCAPE:
                    begin
                        phase = IN_TEXT;
                        case (t.in_byte)
                            CH_QUOTE, CH_BACKSLASH, CH_SLASH:
                                push_result(t.in_byte, 1'b1, 1'b0, ERR_NONE);
                            CH_B: push_result(CH_BS_CTRL, 1'b1, 1'b0, ERR_NONE);
                            CH_F: push_result(CH_FF_CTRL, 1'b1, 1'b0, ERR_NONE);
                            CH_N: push_result(CH_LF_CTRL, 1'b1, 1'b0, ERR_NONE);
                            CH_R: push_result(CH_CR_CTRL, 1'b1, 1'b0, ERR_NONE);
                            CH_T: push_result(CH_TAB_CTRL, 1'b1, 1'b0, ERR_NONE);
                            CH_U:
                            begin
                                phase = IN_UNICODE;
                                clear_unicode();
                            end
                            default: abort(ERR_BAD_ESC);
                        endcase
                    end
                    default:
                    begin
                        nib = nibble_of(t.in_byte);
                        // only the leading run of hex digits contributes
                        if (!run_ended && nib[4])
                        begin
                            code_unit = {code_unit[11:0], nib[3:0]};
                        end
                        else
                        begin
                            run_ended = 1'b1;
                            if (digits_seen == 2'd0)
                            begin
                                first_bad = 1'b1;
                            end
                        end
                        if (digits_seen < 2'd3)
                        begin
                            digits_seen++;
                        end
                        else if (first_bad)
                        begin
                            abort(ERR_BAD_HEX);
                        end
                        else
                        begin
                            cu = code_unit;
                            phase = IN_TEXT;
                            clear_unicode();
                            if (cu <= UTF_MAX1)
                            begin
                                push_result(cu[7:0], 1'b1, 1'b0, ERR_NONE);
                            end
                            else if (cu <= UTF_MAX2)
                            begin
                                push_result(UTF_LEAD2 | 8'(cu >> 6), 1'b1, 1'b0, ERR_NONE);
                                push_result(UTF_CONT | (cu[7:0] & UTF_MASK6), 1'b1, 1'b0,
                                            ERR_NONE);
                            end
                            else
                            begin
                                push_result(UTF_LEAD3 | 8'(cu >> 12), 1'b1, 1'b0, ERR_NONE);
                                push_result(UTF_CONT | (8'(cu >> 6) & UTF_MASK6), 1'b1, 1'b0,
                                            ERR_NONE);
                                push_result(UTF_CONT | (cu[7:0] & UTF_MASK6), 1'b1, 1'b0,
                                            ERR_NONE);
                            end
                        end
                    end
                endcase
            end
            if (decoded_q.size() > start)
            begin
                tail = decoded_q.pop_back();
                tail.last = 1'b1;
                append_result(tail);
            end
        endfunction

        function string show(out_t r);
            return $sformatf("byte=%02h has_byte=%0b last=%0b done=%0b err=%0d",
                             r.out_byte, r.has_byte, r.last, r.string_done, r.error_code);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endfunction

        function void check_output(out_t got);
            out_t want;
            logic bad;
            if (decoded_q.size() == 0)
            begin
                flag({"unexpected result ", show(got)});
                return;
            end
            want = decoded_q.pop_front();
            checked++;
            bad = (got.out_byte !== want.out_byte) || (got.has_byte !== want.has_byte) ||
                  (got.last !== want.last) || (got.string_done !== want.string_done) ||
                  (got.error_code !== want.error_code);
            if (bad)
            begin
                flag({"expected ", show(want), " got ", show(got)});
            end
            if (want.has_byte)
            begin
                bytes_out++;
            end
            if (want.string_done)
            begin
                closed++;
            end
            error_hits[want.error_code]++;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction
    endclass

endpackage

[tb/tb_json_string_unescape.sv]
// tb_json_string_unescape: drives quoted json strings, broken strings and noise
// into the unescape block with random idling on both channels and checks every
// result. Depends on jsu_pkg and jsu_tb_pkg.
module tb_json_string_unescape;

    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;
    import jsu_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 200;

    logic clk;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    in_t  in_data   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;

    decode_scoreboard sb = new();
    in_t  script[$];
    int   cycles = 0;
    logic calm = 1'b0;
    logic [7:0]  escape_letters[8] = '{CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_B, CH_F,
                                        CH_N, CH_R, CH_T};
    logic [15:0] boundary_units[6] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                        16'h0800, 16'hFFFF};

    json_string_unescape uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
        $display("Regression FAIL");
        $finish;
    end

    // mostly no gap, otherwise short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0)
            begin
                stall_left = pick_gap();
            end
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
            begin
                stall_left--;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_output(out_data);
        end
    end

    function automatic in_t char_item(input logic [7:0] c);
        in_t t;
        t.in_byte      = c;
        t.end_of_input = 1'b0;
        return t;
    endfunction

    function automatic in_t end_item();
        in_t t;
        t.in_byte      = 8'($urandom_range(0, 255));
        t.end_of_input = 1'b1;
        return t;
    endfunction

    function automatic void add_item(input in_t t);
        script = {script, t};
    endfunction

    function automatic logic [7:0] random_hex_char();
        return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic logic [7:0] random_non_hex();
        logic [7:0] b;
        logic [4:0] nib;
        do
        begin
            b   = 8'($urandom_range(0, 255));
            nib = nibble_of(b);
        end
        while (nib[4]);
        return b;
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            add_item(char_item(s[i]));
        end
    endtask

    // backslash u plus four characters; the hex run is sometimes cut short
    task automatic add_code_unit();
        logic [15:0] cu;
        int          span;
        int          cut;
        span = $urandom_range(0, 7);
        if (span == 0)
        begin
            cu = boundary_units[$urandom_range(0, 5)];
        end
        else if (span < 3)
        begin
            cu = 16'($urandom_range(0, 16'h7F));
        end
        else if (span < 5)
        begin
            cu = 16'($urandom_range(16'h80, 16'h7FF));
        end
        else
        begin
            cu = 16'($urandom_range(16'h800, 16'hFFFF));
        end
        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 4;
        add_text("\\u");
        for (int i = 0; i < 4; i++)
        begin
            if (i < cut)
            begin
                add_item(char_item(hex_char(cu[15 - 4 * i -: 4],
                                            1'($urandom_range(0, 1)))));
            end
            else if (i == cut)
            begin
                add_item(char_item(random_non_hex()));
            end
            else
            begin
                add_item(char_item(8'($urandom_range(0, 255))));
            end
        end
    endtask

    task automatic add_random_string();
        int         pieces;
        int         ending;
        logic [7:0] b;
        add_item(char_item(CH_QUOTE));
        pieces = $urandom_range(0, 6);
        repeat (pieces)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    do
                    begin
                        b = 8'($urandom_range(0, 255));
                    end
                    while (b == CH_QUOTE || b == CH_BACKSLASH);
                    add_item(char_item(b));
                end
                4, 5, 6:
                begin
                    add_item(char_item(CH_BACKSLASH));
                    add_item(char_item(escape_letters[$urandom_range(0, 7)]));
                end
                default: add_code_unit();
            endcase
        end
        ending = $urandom_range(0, 19);
        if (ending < 13)
        begin
            add_item(char_item(CH_QUOTE));
        end
        else if (ending == 13)
        begin
            add_item(end_item());
        end
        else if (ending == 14)
        begin
            add_item(char_item(CH_BACKSLASH));
            add_item(end_item());
        end
        else if (ending == 15)
        begin
            // anything that is not an escape letter
            do
            begin
                b = 8'($urandom_range(0, 255));
            end
            while (b == CH_QUOTE || b == CH_BACKSLASH || b == CH_SLASH || b == CH_B ||
                   b == CH_F || b == CH_N || b == CH_R || b == CH_T || b == CH_U);
            add_item(char_item(CH_BACKSLASH));
            add_item(char_item(b));
        end
        else if (ending == 16)
        begin
            add_text("\\u");
            repeat ($urandom_range(0, 3))
            begin
                add_item(char_item(random_hex_char()));
            end
            add_item(end_item());
        end
        else if (ending == 17)
        begin
            add_text("\\u");
            add_item(char_item(random_non_hex()));
            repeat (3)
            begin
                add_item(char_item(8'($urandom_range(0, 255))));
            end
        end
        else if (ending == 18)
        begin
            // end of input inside an escape whose first character was bad
            add_text("\\u");
            add_item(char_item(random_non_hex()));
            repeat ($urandom_range(0, 2))
            begin
                add_item(char_item(8'($urandom_range(0, 255))));
            end
            add_item(end_item());
        end
        else
        begin
            add_item(char_item(CH_QUOTE));
            add_item(char_item(8'($urandom_range(0, 255))));
        end
    endtask

    task automatic add_noise();
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                add_item(end_item());
            end
            else
            begin
                add_item(char_item(8'($urandom_range(0, 255))));
            end
        end
    endtask

    task automatic send_item(input in_t t);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            in_data  <= in_t'($urandom_range(0, 511));
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= t;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_input(t);
    endtask

    task automatic send_script();
        while (script.size() > 0)
        begin
            send_item(script.pop_front());
        end
    endtask

    initial
    begin
        int random_sent;
        random_sent = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: end of text and a stray byte while waiting, control and
        // high bytes, largest 3-byte and 2-byte units, bad first hex digit,
        // end of input right after a backslash
        add_item(end_item());
        add_text("A");
        add_text("\"");
        add_item(char_item(8'h00));
        add_item(char_item(8'hFF));
        add_text("\\uFfFF\"");
        add_text("\"\\uz123");
        add_text("\"\\u07FF\\");
        add_item(end_item());
        send_script();

        while (random_sent < RANDOM_ITEMS)
        begin
            calm = (random_sent >= 80 && random_sent < 130);
            if ($urandom_range(0, 9) < 8)
            begin
                add_random_string();
            end
            else
            begin
                add_noise();
            end
            random_sent += script.size();
            send_script();
        end
        calm = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("%0d input transactions, %0d results: %0d strings closed, %0d bytes decoded",
                 sb.inputs_seen, sb.checked, sb.closed, sb.bytes_out);
        $display("error codes 1..6 seen %0d %0d %0d %0d %0d %0d, %0d mismatches",
                 sb.error_hits[ERR_NO_OPEN], sb.error_hits[ERR_UNTERM],
                 sb.error_hits[ERR_END_ESC], sb.error_hits[ERR_END_UNI],
                 sb.error_hits[ERR_BAD_HEX], sb.error_hits[ERR_BAD_ESC], sb.mismatches);
        if (sb.mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
